// ===== rtl/core/ktls_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ktls_pkg: shared types and constants for the keyed table search block
// Table geometry, operation and status codes, and the structs passed
// between the command queue, the search engine and the result queue.
// ----------------------------------------------------------------------------
package ktls_pkg;

  localparam int TABLE_DEPTH = 128;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W       = 64;
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 2;
  localparam int POS_W       = 7;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_LINEAR = 2'd1,
    OP_BINARY = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef struct packed {
    op_t              op;
    logic [KEY_W-1:0] key;
  } cmd_t;

  typedef struct packed {
    status_t          status;
    logic [POS_W-1:0] position;
  } res_t;

  typedef struct packed {
    logic             busy;
    logic             res_pend;
    logic [CNT_W-1:0] count;
  } eng_stat_t;

endpackage : ktls_pkg
`default_nettype wire

// ===== rtl/core/ktls_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ktls_front: input side command queue
// Accepts items on the push/full side, decodes the operation code and
// holds up to two commands for the engine.
// ----------------------------------------------------------------------------
module ktls_front (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     push,
  output logic                          full,
  input  wire logic [ktls_pkg::OP_W-1:0]  in_op,
  input  wire logic [ktls_pkg::KEY_W-1:0] in_key,
  output logic                          cmd_valid_o,
  output ktls_pkg::cmd_t                cmd_o,
  input  wire logic                     cmd_pop_i
);
  import ktls_pkg::*;

  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       push_ok, pop_ok;
  cmd_t       cmd_dec;

  always_comb begin
    cmd_dec.op  = op_t'(in_op);
    cmd_dec.key = in_key;
  end

  assign full        = (fill_r == 2'd2);
  assign cmd_valid_o = (fill_r != 2'd0);
  assign cmd_o       = q_r[rd_ptr_r];
  assign push_ok     = push && !full;
  assign pop_ok      = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push_ok;
    rd_ptr_nxt = rd_ptr_r ^ pop_ok;
    fill_nxt   = fill_r + {1'b0, push_ok} - {1'b0, pop_ok};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wr_ptr_r] <= cmd_dec;
    end
  end

endmodule : ktls_front
`default_nettype wire

// ===== rtl/core/ktls_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ktls_engine: key table and search sequencer
// Owns the key memory and entry count. Appends and clears finish at once;
// linear search scans the memory, binary search runs an in-place insertion
// sort and then probes the sorted table.
// ----------------------------------------------------------------------------
module ktls_engine (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cmd_valid_i,
  input  wire ktls_pkg::cmd_t cmd_i,
  output logic               cmd_pop_o,
  output logic               res_valid_o,
  output ktls_pkg::res_t     res_o,
  input  wire logic          res_ready_i,
  output ktls_pkg::eng_stat_t stat_o
);
  import ktls_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_LIN      = 7'b0000010,
    S_SORT_V   = 7'b0000100,
    S_SORT_CMP = 7'b0001000,
    S_SORT_PUT = 7'b0010000,
    S_BPROBE   = 7'b0100000,
    S_BCMP     = 7'b1000000
  } eng_state_t;

  eng_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [ADDR_W-1:0] j_r, j_nxt;
  logic [ADDR_W-1:0] mid_r, mid_nxt;
  logic [KEY_W-1:0] v_r, v_nxt;
  logic [CNT_W-1:0] lo_r, lo_nxt;
  logic [CNT_W-1:0] hip1_r, hip1_nxt;
  res_t             res_r, res_nxt;
  logic             res_valid_r, res_valid_nxt;

  logic [KEY_W-1:0]  mem [TABLE_DEPTH];
  logic [KEY_W-1:0]  rdata_r;
  logic              we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [KEY_W-1:0]  wdata;

  logic [CNT_W-1:0] idx_p1;
  logic [CNT_W-1:0] mid_calc;

  assign idx_p1   = CNT_W'(idx_r) + CNT_W'(1);
  // floor midpoint of [lo, hi], with hi = hip1 - 1 and lo <= hi
  assign mid_calc = lo_r + ((hip1_r - CNT_W'(1) - lo_r) >> 1);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd_nxt       = cmd_r;
    idx_nxt       = idx_r;
    j_nxt         = j_r;
    mid_nxt       = mid_r;
    v_nxt         = v_r;
    lo_nxt        = lo_r;
    hip1_nxt      = hip1_r;
    res_nxt       = res_r;
    res_valid_nxt = res_valid_r && !res_ready_i;
    cmd_pop_o     = 1'b0;
    we            = 1'b0;
    waddr         = '0;
    wdata         = '0;
    raddr         = '0;

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid_i && !res_valid_r) begin
          cmd_pop_o = 1'b1;
          cmd_nxt   = cmd_i;
          unique case (cmd_i.op)
            OP_APPEND: begin
              res_valid_nxt = 1'b1;
              if (cnt_r == CNT_W'(TABLE_DEPTH)) begin
                res_nxt = '{status: ST_FULL, position: '0};
              end else begin
                we      = 1'b1;
                waddr   = cnt_r[ADDR_W-1:0];
                wdata   = cmd_i.key;
                res_nxt = '{status: ST_OK, position: POS_W'(cnt_r)};
                cnt_nxt = cnt_r + CNT_W'(1);
              end
            end
            OP_LINEAR: begin
              if (cnt_r == '0) begin
                res_valid_nxt = 1'b1;
                res_nxt       = '{status: ST_MISS, position: '0};
              end else begin
                raddr     = '0;
                idx_nxt   = '0;
                state_nxt = S_LIN;
              end
            end
            OP_BINARY: begin
              if (cnt_r <= CNT_W'(1)) begin
                lo_nxt    = '0;
                hip1_nxt  = cnt_r;
                state_nxt = S_BPROBE;
              end else begin
                raddr     = ADDR_W'(1);
                idx_nxt   = ADDR_W'(1);
                state_nxt = S_SORT_V;
              end
            end
            OP_CLEAR: begin
              cnt_nxt       = '0;
              res_valid_nxt = 1'b1;
              res_nxt       = '{status: ST_OK, position: '0};
            end
            default: ;
          endcase
        end
      end

      S_LIN: begin
        if (rdata_r == cmd_r.key) begin
          res_valid_nxt = 1'b1;
          res_nxt       = '{status: ST_OK, position: POS_W'(idx_r)};
          state_nxt     = S_IDLE;
        end else if (idx_p1 == cnt_r) begin
          res_valid_nxt = 1'b1;
          res_nxt       = '{status: ST_MISS, position: '0};
          state_nxt     = S_IDLE;
        end else begin
          raddr   = idx_r + ADDR_W'(1);
          idx_nxt = idx_r + ADDR_W'(1);
        end
      end

      // insertion sort: hold key i in v_r, shift larger keys up one slot
      S_SORT_V: begin
        v_nxt     = rdata_r;
        j_nxt     = idx_r;
        raddr     = idx_r - ADDR_W'(1);
        state_nxt = S_SORT_CMP;
      end

      S_SORT_CMP: begin
        we    = 1'b1;
        waddr = j_r;
        if (rdata_r > v_r) begin
          wdata = rdata_r;
          j_nxt = j_r - ADDR_W'(1);
          if (j_r == ADDR_W'(1)) begin
            state_nxt = S_SORT_PUT;
          end else begin
            raddr = j_r - ADDR_W'(2);
          end
        end else begin
          wdata = v_r;
          if (idx_p1 == cnt_r) begin
            lo_nxt    = '0;
            hip1_nxt  = cnt_r;
            state_nxt = S_BPROBE;
          end else begin
            raddr     = idx_r + ADDR_W'(1);
            idx_nxt   = idx_r + ADDR_W'(1);
            state_nxt = S_SORT_V;
          end
        end
      end

      S_SORT_PUT: begin
        we    = 1'b1;
        waddr = j_r;
        wdata = v_r;
        if (idx_p1 == cnt_r) begin
          lo_nxt    = '0;
          hip1_nxt  = cnt_r;
          state_nxt = S_BPROBE;
        end else begin
          raddr     = idx_r + ADDR_W'(1);
          idx_nxt   = idx_r + ADDR_W'(1);
          state_nxt = S_SORT_V;
        end
      end

      S_BPROBE: begin
        if (lo_r >= hip1_r) begin
          res_valid_nxt = 1'b1;
          res_nxt       = '{status: ST_MISS, position: '0};
          state_nxt     = S_IDLE;
        end else begin
          raddr     = mid_calc[ADDR_W-1:0];
          mid_nxt   = mid_calc[ADDR_W-1:0];
          state_nxt = S_BCMP;
        end
      end

      S_BCMP: begin
        if (rdata_r == cmd_r.key) begin
          res_valid_nxt = 1'b1;
          res_nxt       = '{status: ST_OK, position: POS_W'(mid_r)};
          state_nxt     = S_IDLE;
        end else begin
          if (rdata_r < cmd_r.key) begin
            lo_nxt = CNT_W'(mid_r) + CNT_W'(1);
          end else begin
            hip1_nxt = CNT_W'(mid_r);
          end
          state_nxt = S_BPROBE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    idx_r  <= idx_nxt;
    j_r    <= j_nxt;
    mid_r  <= mid_nxt;
    v_r    <= v_nxt;
    lo_r   <= lo_nxt;
    hip1_r <= hip1_nxt;
    res_r  <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign res_valid_o     = res_valid_r;
  assign res_o           = res_r;
  assign stat_o.busy     = (state_r != S_IDLE);
  assign stat_o.res_pend = res_valid_r;
  assign stat_o.count    = cnt_r;

endmodule : ktls_engine
`default_nettype wire

// ===== rtl/core/ktls_out_q.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ktls_out_q: result queue
// Two-entry queue between the engine and the empty/pop side, so a finished
// result can wait while the engine takes the next command.
// ----------------------------------------------------------------------------
module ktls_out_q (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          res_valid_i,
  input  wire ktls_pkg::res_t                res_i,
  output logic                               res_ready_o,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [ktls_pkg::STATUS_W-1:0]      out_status,
  output logic [ktls_pkg::POS_W-1:0]         out_position
);
  import ktls_pkg::*;

  res_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       push_ok, pop_ok;
  res_t       head;

  assign res_ready_o  = (fill_r != 2'd2);
  assign empty        = (fill_r == 2'd0);
  assign push_ok      = res_valid_i && res_ready_o;
  assign pop_ok       = pop && !empty;
  assign head         = q_r[rd_ptr_r];
  assign out_status   = head.status;
  assign out_position = head.position;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push_ok;
    rd_ptr_nxt = rd_ptr_r ^ pop_ok;
    fill_nxt   = fill_r + {1'b0, push_ok} - {1'b0, pop_ok};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wr_ptr_r] <= res_i;
    end
  end

endmodule : ktls_out_q
`default_nettype wire

// ===== rtl/core/keyed_table_linear_binary_search.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_table_linear_binary_search: key table with linear and binary search
// Appends 64-bit keys to a table, clears it, and answers linear or
// sort-then-binary queries, one result item per input item.
// ----------------------------------------------------------------------------
//  channel  | handshake        | payload
//  ---------+------------------+-------------------------------
//  input    | push / full      | in_op[1:0], in_key[63:0]
//  result   | empty / pop      | out_status[1:0], out_position[6:0]
//
// Append and clear are done by the engine in its idle state; their answer goes
// through the engine result register and the result queue to the result ports.
// Linear search reads one entry per cycle through the single memory read port.
// Binary search first insertion-sorts the table in place (when it holds two or
// more keys), then probes the sorted table with a read and a compare per probe.
// No clearing pass after reset: the table count starts at zero.
// Either side may stall; two-entry queues on both sides decouple them.
// ----------------------------------------------------------------------------
module keyed_table_linear_binary_search (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [ktls_pkg::OP_W-1:0]     in_op,
  input  wire logic [ktls_pkg::KEY_W-1:0]    in_key,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [ktls_pkg::STATUS_W-1:0]      out_status,
  output logic [ktls_pkg::POS_W-1:0]         out_position
);
  import ktls_pkg::*;

  logic      cmd_valid;
  cmd_t      cmd;
  logic      cmd_pop;
  logic      res_valid;
  res_t      res;
  logic      res_ready;
  eng_stat_t eng_stat;

  ktls_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .in_op       (in_op),
    .in_key      (in_key),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  ktls_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready),
    .stat_o      (eng_stat)
  );

  ktls_out_q u_out_q (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid_i  (res_valid),
    .res_i        (res),
    .res_ready_o  (res_ready),
    .empty        (empty),
    .pop          (pop),
    .out_status   (out_status),
    .out_position (out_position)
  );

  // entry count never runs past the table
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    eng_stat.count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // a pending result means the sequencer is back at rest
  a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    eng_stat.res_pend |-> !eng_stat.busy)
    else $error("engine busy with an undelivered result");

  // engine never pops a command while it still holds a result
  a_no_pop_pend: assert property (@(posedge clk) disable iff (!rst_n)
    eng_stat.res_pend |-> !cmd_pop)
    else $error("command taken while result pending");

  // misses and full answers carry position zero
  a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_status != ST_OK) |-> (out_position == '0))
    else $error("nonzero position on a failed item");

endmodule : keyed_table_linear_binary_search
`default_nettype wire
